// File: src/ttc_pkg.sv
// Shared types and constants for the triangle tangent unit.
// No dependencies; used by ttc_mul, ttc_div and triangle_tangent_calc.
`timescale 1ns / 1ps

package ttc_pkg;

  // Field and datapath widths
  localparam int FIELD_W = 32;               // Q16.16 input and output fields
  localparam int DELTA_W = FIELD_W + 1;      // exact edge / UV delta
  localparam int PROD_W  = 2 * DELTA_W;      // exact product of two deltas
  localparam int SUM_W   = PROD_W + 1;       // difference of two products
  localparam int FRAC_W  = 16;               // fraction bits (the 1.0 scale)
  localparam int QUO_W   = FIELD_W;          // quotient bits produced
  localparam int DIV_CNT_W = $clog2(QUO_W);

  // Products issued per triangle: det pair plus three numerator pairs
  localparam int MUL_STEPS = 8;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS) + 1;

  // Vertex position within a triangle
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // Sum slots from the multiplier: determinant, then x, y, z numerators
  localparam logic [1:0] SLOT_DET  = 2'd0;
  localparam logic [1:0] SLOT_LAST = 2'd3;

  localparam logic [1:0] COMP_LAST = 2'd2;   // z component / third result

  localparam logic signed [1:0] HAND_POS = 2'sb01;
  localparam logic signed [1:0] HAND_NEG = 2'sb11;

  localparam logic [QUO_W-1:0] QUO_POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] QUO_NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } ttc_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_ABS,
    DV_CHK,
    DV_RUN,
    DV_FIN
  } ttc_div_state_t;

  typedef struct packed {
    logic valid;   // operands on the multiplier inputs this cycle
    logic second;  // product is subtracted from the held first product
  } ttc_mul_ctl_t;

endpackage

// File: src/ttc_mul.sv
// Shared multiply-subtract unit: registered 33x33 signed product, then a*b - c*d.
// Depends on ttc_pkg.
`timescale 1ns / 1ps

module ttc_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ttc_pkg::ttc_mul_ctl_t              ctl,
  input  logic signed [ttc_pkg::DELTA_W-1:0] op_a,
  input  logic signed [ttc_pkg::DELTA_W-1:0] op_b,
  output logic signed [ttc_pkg::SUM_W-1:0]   res,
  output logic                               res_vld
);

  logic signed [ttc_pkg::PROD_W-1:0] prod_r;
  logic signed [ttc_pkg::PROD_W-1:0] acc_r;
  logic signed [ttc_pkg::SUM_W-1:0]  res_r;
  logic signed [ttc_pkg::SUM_W-1:0]  diff;
  ttc_pkg::ttc_mul_ctl_t             ctl_d_r;
  logic                              res_vld_r;

  assign diff = $signed({acc_r[ttc_pkg::PROD_W-1], acc_r})
              - $signed({prod_r[ttc_pkg::PROD_W-1], prod_r});

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_d_r.valid && !ctl_d_r.second) begin
      acc_r <= prod_r;
    end
    if (ctl_d_r.valid && ctl_d_r.second) begin
      res_r <= diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      ctl_d_r   <= ctl;
      res_vld_r <= ctl_d_r.valid && ctl_d_r.second;
    end
  end

  assign res     = res_r;
  assign res_vld = res_vld_r;

endmodule

// File: src/ttc_div.sv
// Iterative signed divider: (num * 2^16) / den, truncated, saturated to 32 bits.
// One quotient bit per cycle. Depends on ttc_pkg.
`timescale 1ns / 1ps

module ttc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ttc_pkg::SUM_W-1:0]   num,
  input  logic signed [ttc_pkg::SUM_W-1:0]   den,
  output logic signed [ttc_pkg::FIELD_W-1:0] quo,
  output logic                               done
);

  localparam int MW = ttc_pkg::SUM_W;
  localparam int QW = ttc_pkg::QUO_W;
  localparam int FW = ttc_pkg::FRAC_W;

  ttc_pkg::ttc_div_state_t state_r, state_nxt;

  logic                              neg_r;
  logic [MW-1:0]                     magn_r;
  logic [MW-1:0]                     magd_r;
  logic [MW-1:0]                     rem_r;
  logic [QW-1:0]                     lo_r;
  logic [QW-1:0]                     q_r;
  logic                              ovf_r;
  logic [ttc_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic signed [ttc_pkg::FIELD_W-1:0] quo_r;
  logic                              done_r;

  logic [MW-1:0] hi_part;
  logic [MW:0]   trial;
  logic [QW-1:0] limit;
  logic [QW-1:0] q_sat;
  logic          last_bit;

  // Upper part of the shifted dividend; at or above the divisor the quotient
  // needs more than 32 bits.
  assign hi_part  = {{(MW-(MW+FW-QW)){1'b0}}, magn_r[MW-1:QW-FW]};
  assign trial    = {rem_r, lo_r[QW-1]} - {1'b0, magd_r};
  assign limit    = neg_r ? ttc_pkg::QUO_NEG_MAX : ttc_pkg::QUO_POS_MAX;
  assign q_sat    = (ovf_r || (q_r > limit)) ? limit : q_r;
  assign last_bit = (cnt_r == ttc_pkg::DIV_CNT_W'(QW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttc_pkg::DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == ttc_pkg::DV_FIN);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttc_pkg::DV_IDLE: if (start) state_nxt = ttc_pkg::DV_ABS;
      ttc_pkg::DV_ABS:  state_nxt = ttc_pkg::DV_CHK;
      ttc_pkg::DV_CHK:  state_nxt = ttc_pkg::DV_RUN;
      ttc_pkg::DV_RUN:  if (last_bit) state_nxt = ttc_pkg::DV_FIN;
      ttc_pkg::DV_FIN:  state_nxt = ttc_pkg::DV_IDLE;
      default:          state_nxt = ttc_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ttc_pkg::DV_ABS: begin
        neg_r  <= num[MW-1] ^ den[MW-1];
        magn_r <= num[MW-1] ? (~num + 1'b1) : num;
        magd_r <= den[MW-1] ? (~den + 1'b1) : den;
      end
      ttc_pkg::DV_CHK: begin
        ovf_r <= (hi_part >= magd_r);
        rem_r <= hi_part;
        lo_r  <= {magn_r[QW-FW-1:0], {FW{1'b0}}};
        q_r   <= '0;
        cnt_r <= '0;
      end
      ttc_pkg::DV_RUN: begin
        // restoring step: keep the trial difference when it did not borrow
        if (!trial[MW]) begin
          rem_r <= trial[MW-1:0];
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[MW-2:0], lo_r[QW-1]};
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        lo_r  <= {lo_r[QW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      ttc_pkg::DV_FIN: begin
        quo_r <= neg_r ? $signed(~q_sat + 1'b1) : $signed(q_sat);
      end
      default: ;
    endcase
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: src/triangle_tangent_calc.sv
// Top level of the per-triangle tangent unit: vertex hold, sequencer, output.
// Depends on ttc_pkg, ttc_mul and ttc_div.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_pos_x/y/z, in_tex_u/v
//   out      source     out_valid / out_stall  out_tangent_x/y/z, out_handedness,
//                                              out_degenerate, out_last_of_triangle
//   cfg      sink       cfg_we                 cfg_wdata (flip_binormals)
//
// First and second vertex of a triangle: held only, no result and no input stall.
// Third vertex: 8 products on the shared multiplier, a determinant check, then three divisions
// on the 32-step shared divider (skipped when det is zero), then three result
// transactions, one per cycle while out_stall is low. When det is nonzero the divider sets the rate.
// in_stall stays high from the third vertex until its last result is taken.
// Synchronous active-low reset clears the vertex phase, sequencer and flip bit.
`timescale 1ns / 1ps

module triangle_tangent_calc (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ttc_pkg::FIELD_W-1:0] in_pos_x,
  input  logic signed [ttc_pkg::FIELD_W-1:0] in_pos_y,
  input  logic signed [ttc_pkg::FIELD_W-1:0] in_pos_z,
  input  logic signed [ttc_pkg::FIELD_W-1:0] in_tex_u,
  input  logic signed [ttc_pkg::FIELD_W-1:0] in_tex_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ttc_pkg::FIELD_W-1:0] out_tangent_x,
  output logic signed [ttc_pkg::FIELD_W-1:0] out_tangent_y,
  output logic signed [ttc_pkg::FIELD_W-1:0] out_tangent_z,
  output logic signed [1:0]                  out_handedness,
  output logic                               out_degenerate,
  output logic                               out_last_of_triangle,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata
);

  localparam int FW = ttc_pkg::FIELD_W;
  localparam int DW = ttc_pkg::DELTA_W;
  localparam int SW = ttc_pkg::SUM_W;

  ttc_pkg::ttc_state_t state_r, state_nxt;

  logic [1:0]                    phase_r;
  logic                          flip_r;
  logic signed [1:0]             hand_r;
  logic signed [FW-1:0]          pos0_r [3];
  logic signed [FW-1:0]          pos1_r [3];
  logic signed [FW-1:0]          tex0_r [2];
  logic signed [FW-1:0]          tex1_r [2];
  logic signed [DW-1:0]          e1_r   [3];
  logic signed [DW-1:0]          e2_r   [3];
  logic signed [DW-1:0]          d1u_r, d1v_r, d2u_r, d2v_r;
  logic [ttc_pkg::MUL_CNT_W-1:0] iss_cnt_r;
  logic [1:0]                    slot_r;
  logic signed [SW-1:0]          det_r;
  logic signed [SW-1:0]          num_r  [3];
  logic [1:0]                    comp_r;
  logic signed [FW-1:0]          tan_r  [3];
  logic                          degen_r;
  logic [1:0]                    out_cnt_r;

  logic signed [FW-1:0] in_pos [3];
  logic                 in_acc;
  logic                 out_acc;
  logic                 tri_acc;
  logic                 det_zero;

  ttc_pkg::ttc_mul_ctl_t mul_ctl;
  logic signed [DW-1:0]  mul_a, mul_b;
  logic signed [SW-1:0]  mul_res;
  logic                  mul_res_vld;
  logic                  div_start;
  logic signed [FW-1:0]  div_quo;
  logic                  div_done;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;

  assign in_stall  = (state_r != ttc_pkg::ST_IDLE);
  assign out_valid = (state_r == ttc_pkg::ST_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign tri_acc   = in_acc && (phase_r == ttc_pkg::PH_THIRD);
  assign det_zero  = (det_r == '0);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    mul_ctl.valid = 1'b0;
    mul_ctl.second = iss_cnt_r[0];
    unique case (state_r)
      ttc_pkg::ST_IDLE: begin
        if (tri_acc) state_nxt = ttc_pkg::ST_MUL;
      end
      ttc_pkg::ST_MUL: begin
        mul_ctl.valid = !iss_cnt_r[ttc_pkg::MUL_CNT_W-1];
        if (mul_res_vld && slot_r == ttc_pkg::SLOT_LAST) state_nxt = ttc_pkg::ST_CHK;
      end
      ttc_pkg::ST_CHK: begin
        state_nxt = det_zero ? ttc_pkg::ST_OUT : ttc_pkg::ST_DSTART;
      end
      ttc_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ttc_pkg::ST_DWAIT;
      end
      ttc_pkg::ST_DWAIT: begin
        if (div_done) begin
          state_nxt = (comp_r == ttc_pkg::COMP_LAST) ? ttc_pkg::ST_OUT : ttc_pkg::ST_DSTART;
        end
      end
      ttc_pkg::ST_OUT: begin
        if (out_acc && out_cnt_r == ttc_pkg::COMP_LAST) state_nxt = ttc_pkg::ST_IDLE;
      end
      default: state_nxt = ttc_pkg::ST_IDLE;
    endcase
  end

  // -------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ttc_pkg::PH_FIRST;
      flip_r    <= 1'b0;
      iss_cnt_r <= '0;
      slot_r    <= ttc_pkg::SLOT_DET;
      comp_r    <= '0;
      out_cnt_r <= '0;
    end else begin
      if (cfg_we) flip_r <= cfg_wdata;
      if (in_acc) begin
        phase_r <= (phase_r == ttc_pkg::PH_SECOND) ? ttc_pkg::PH_THIRD
                 : (phase_r == ttc_pkg::PH_THIRD)  ? ttc_pkg::PH_FIRST
                 : ttc_pkg::PH_SECOND;
      end
      if (tri_acc) begin
        iss_cnt_r <= '0;
        slot_r    <= ttc_pkg::SLOT_DET;
        comp_r    <= '0;
        out_cnt_r <= '0;
      end else begin
        if (mul_ctl.valid) iss_cnt_r <= iss_cnt_r + 1'b1;
        if (mul_res_vld)   slot_r    <= slot_r + 1'b1;
        if (state_r == ttc_pkg::ST_DWAIT && div_done) comp_r <= comp_r + 1'b1;
        if (out_acc) out_cnt_r <= out_cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc && phase_r == ttc_pkg::PH_SECOND) begin
      for (int i = 0; i < 3; i++) pos1_r[i] <= in_pos[i];
      tex1_r[0] <= in_tex_u;
      tex1_r[1] <= in_tex_v;
    end
    // phase value three behaves as the first vertex
    if (in_acc && phase_r != ttc_pkg::PH_SECOND && phase_r != ttc_pkg::PH_THIRD) begin
      for (int i = 0; i < 3; i++) pos0_r[i] <= in_pos[i];
      tex0_r[0] <= in_tex_u;
      tex0_r[1] <= in_tex_v;
    end
    if (tri_acc) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= {pos1_r[i][FW-1], pos1_r[i]} - {pos0_r[i][FW-1], pos0_r[i]};
        e2_r[i] <= {in_pos[i][FW-1], in_pos[i]} - {pos0_r[i][FW-1], pos0_r[i]};
      end
      d1u_r  <= {tex1_r[0][FW-1], tex1_r[0]} - {tex0_r[0][FW-1], tex0_r[0]};
      d1v_r  <= {tex1_r[1][FW-1], tex1_r[1]} - {tex0_r[1][FW-1], tex0_r[1]};
      d2u_r  <= {in_tex_u[FW-1], in_tex_u} - {tex0_r[0][FW-1], tex0_r[0]};
      d2v_r  <= {in_tex_v[FW-1], in_tex_v} - {tex0_r[1][FW-1], tex0_r[1]};
      hand_r <= flip_r ? ttc_pkg::HAND_NEG : ttc_pkg::HAND_POS;
    end
    if (mul_res_vld) begin
      if (slot_r == ttc_pkg::SLOT_DET) begin
        det_r <= mul_res;
      end else begin
        num_r[slot_r - 2'd1] <= mul_res;
      end
    end
    if (state_r == ttc_pkg::ST_CHK) begin
      degen_r <= det_zero;
      // zero determinant: force the tangent to zero
      if (det_zero) begin
        for (int i = 0; i < 3; i++) tan_r[i] <= '0;
      end
    end
    if (state_r == ttc_pkg::ST_DWAIT && div_done) begin
      tan_r[comp_r] <= div_quo;
    end
  end

  // Operand pairs: det = d1u*d2v - d1v*d2u, num[i] = e1[i]*d2v - e2[i]*d1v
  always_comb begin
    case (iss_cnt_r[ttc_pkg::MUL_CNT_W-2:0])
      3'd0:    begin mul_a = d1u_r;   mul_b = d2v_r; end
      3'd1:    begin mul_a = d1v_r;   mul_b = d2u_r; end
      3'd2:    begin mul_a = e1_r[0]; mul_b = d2v_r; end
      3'd3:    begin mul_a = e2_r[0]; mul_b = d1v_r; end
      3'd4:    begin mul_a = e1_r[1]; mul_b = d2v_r; end
      3'd5:    begin mul_a = e2_r[1]; mul_b = d1v_r; end
      3'd6:    begin mul_a = e1_r[2]; mul_b = d2v_r; end
      default: begin mul_a = e2_r[2]; mul_b = d1v_r; end
    endcase
  end

  ttc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .res     (mul_res),
    .res_vld (mul_res_vld)
  );

  ttc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[comp_r]),
    .den   (det_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign out_tangent_x        = tan_r[0];
  assign out_tangent_y        = tan_r[1];
  assign out_tangent_z        = tan_r[2];
  assign out_handedness       = hand_r;
  assign out_degenerate       = degen_r;
  assign out_last_of_triangle = (out_cnt_r == ttc_pkg::COMP_LAST);

endmodule
